// ===== rtl/core/lzcd_pkg.sv =====
package lzcd_pkg;

	localparam int CHUNK_BYTES = 32;
	localparam int WINDOW_DEFAULT = 131072;
	localparam int CNT_W = $clog2(CHUNK_BYTES + 1);
	localparam int SIZE_W = 24;
	localparam int DIST_W = 18;
	localparam int LEN_W = 11;
	localparam int TDATA_W = 288;

	localparam logic [7:0] CMD_SHORT_LIM = 8'h80;
	localparam logic [7:0] CMD_MID_LIM = 8'hC0;
	localparam logic [7:0] CMD_LONG_LIM = 8'hE0;
	localparam logic [7:0] CMD_STOP_LIM = 8'hFC;

	typedef enum logic [8:0] {
		PH_FLAGS   = 9'b000000001,
		PH_MAGIC   = 9'b000000010,
		PH_SKIP    = 9'b000000100,
		PH_SIZE    = 9'b000001000,
		PH_CMD     = 9'b000010000,
		PH_CMDMORE = 9'b000100000,
		PH_LITPRE  = 9'b001000000,
		PH_LITRUN  = 9'b010000000,
		PH_TRAIL   = 9'b100000000
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CRD  = 4'b0010,
		ST_CWR  = 4'b0100,
		ST_FIN  = 4'b1000
	} seq_state_t;

	typedef struct packed {
		logic       push;
		logic [7:0] data;
		logic       fin;
		logic       stream_end;
		logic       bad;
	} pk_ctl_t;

	typedef struct packed {
		logic push_ready;
		logic fin_ready;
	} pk_stat_t;

endpackage

// ===== rtl/core/lz_command_stream_decompressor_core.sv =====
// Takes one compressed byte per accepted input word and emits the decoded bytes in words of
// up to 32 bytes; the last word caused by an input byte carries tlast. A header or command
// byte is accepted; a literal byte is accepted and then, unless a copy follows, its
// output word is closed; every copied byte is a history read followed by a write-back, and
// the output word is closed after the last copied byte. The copy speed is set by the single
// history memory port pair, and a stalled output holds the copy. The history memory needs
// no clearing after reset.
module lz_command_stream_decompressor_core #(
	parameter int WINDOW_BYTES = lzcd_pkg::WINDOW_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // in_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_lane0..3, byte_count, total_size, zero fill
	output logic [lzcd_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast,   // chunk_last
	output logic [1:0]                    m_axis_tuser    // stream_end, bad_distance
);
	import lzcd_pkg::*;

	localparam int AW = $clog2(WINDOW_BYTES);

	phase_t     phase_q;
	seq_state_t st_q;
	logic [31:0]       cmd_q;
	logic [2:0]        idx_q;
	logic [6:0]        lit_q;
	logic [SIZE_W-1:0] bw_q, size_q;
	logic              skip_q, en_q, bad_q, end_q;
	logic [DIST_W-1:0] dist_q;
	logic [LEN_W-1:0]  len_q;

	pk_ctl_t  ctl;
	pk_stat_t stat;
	logic [7:0] rdata;
	logic acc, lit_push, re;
	logic [AW-1:0] raddr;
	logic [SIZE_W-1:0] bw_after, rd_full;
	logic [7:0] b, b0, b1, b2, b3;
	logic [31:0] cb;
	logic [2:0] clen, idx_nx;
	logic [1:0] d_lits;
	logic [DIST_W-1:0] d_dist, c_dist;
	logic [LEN_W-1:0] d_len;
	logic c_bad;

	assign b = s_axis_tdata;
	assign s_axis_tready = (st_q == ST_IDLE) && stat.push_ready;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign lit_push = acc && (phase_q == PH_LITPRE || phase_q == PH_LITRUN ||
		phase_q == PH_TRAIL);
	assign bw_after = bw_q + SIZE_W'(lit_push);

	always_comb begin
		cb = cmd_q;
		unique case (idx_q[1:0])
			2'd1: cb[15:8] = b;
			2'd2: cb[23:16] = b;
			2'd3: cb[31:24] = b;
			default: cb[7:0] = b;
		endcase
		b0 = cb[7:0];
		b1 = cb[15:8];
		b2 = cb[23:16];
		b3 = cb[31:24];
		idx_nx = idx_q + 3'd1;
		priority if (b0 < CMD_SHORT_LIM) begin
			clen = 3'd2;
			d_lits = b0[1:0];
			d_len = LEN_W'(b0[4:2]) + LEN_W'(3);
			d_dist = DIST_W'({b0[6:5], b1}) + DIST_W'(1);
		end else if (b0 < CMD_MID_LIM) begin
			clen = 3'd3;
			d_lits = b1[7:6];
			d_len = LEN_W'(b0[5:0]) + LEN_W'(4);
			d_dist = DIST_W'({b1[5:0], b2}) + DIST_W'(1);
		end else begin
			clen = 3'd4;
			d_lits = b0[1:0];
			d_len = LEN_W'({b0[3:2], b3}) + LEN_W'(5);
			d_dist = DIST_W'({b0[4], b1, b2}) + DIST_W'(1);
		end
		c_dist = (phase_q == PH_CMDMORE) ? d_dist : dist_q;
		c_bad = (SIZE_W'(c_dist) > bw_after) || (32'(c_dist) > 32'(WINDOW_BYTES));
	end

	assign re = (st_q == ST_CRD);
	assign rd_full = bw_q - SIZE_W'(dist_q);
	assign raddr = rd_full[AW-1:0];

	always_comb begin
		ctl.push = lit_push || (st_q == ST_CWR && stat.push_ready);
		ctl.data = lit_push ? b : (bad_q ? 8'h00 : rdata);
		ctl.fin = (st_q == ST_FIN) && stat.fin_ready;
		ctl.stream_end = end_q;
		ctl.bad = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			st_q <= ST_IDLE;
			cmd_q <= '0;
			idx_q <= '0;
			lit_q <= '0;
			bw_q <= '0;
			size_q <= '0;
			skip_q <= 1'b0;
			dist_q <= '0;
			len_q <= '0;
			en_q <= 1'b1;
			bad_q <= 1'b0;
			end_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (ctl.push) begin
				bw_q <= bw_q + SIZE_W'(1);
			end
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						bad_q <= 1'b0;
						end_q <= 1'b0;
						unique case (phase_q)
							PH_FLAGS: begin
								skip_q <= b[0];
								size_q <= '0;
								bw_q <= '0;
								idx_q <= '0;
								phase_q <= PH_MAGIC;
							end
							PH_MAGIC: begin
								idx_q <= '0;
								phase_q <= skip_q ? PH_SKIP : PH_SIZE;
							end
							PH_SKIP: begin
								idx_q <= idx_nx;
								if (idx_nx >= 3'd3) begin
									idx_q <= '0;
									phase_q <= PH_SIZE;
								end
							end
							PH_SIZE: begin
								size_q <= {size_q[15:0], b};
								idx_q <= idx_nx;
								if (idx_nx >= 3'd3) begin
									idx_q <= '0;
									if (en_q) begin
										phase_q <= PH_CMD;
									end else begin
										end_q <= 1'b1;
										phase_q <= PH_FLAGS;
										st_q <= ST_FIN;
									end
								end
							end
							PH_CMD: begin
								cmd_q <= {24'h0, b};
								idx_q <= 3'd1;
								priority if (b < CMD_LONG_LIM) begin
									phase_q <= PH_CMDMORE;
								end else if (b < CMD_STOP_LIM) begin
									lit_q <= {b[4:0] + 5'd1, 2'b00};
									phase_q <= PH_LITRUN;
								end else begin
									lit_q <= {5'd0, b[1:0]};
									if (b[1:0] == 2'd0) begin
										end_q <= 1'b1;
										phase_q <= PH_FLAGS;
										st_q <= ST_FIN;
									end else begin
										phase_q <= PH_TRAIL;
									end
								end
							end
							PH_CMDMORE: begin
								cmd_q <= cb;
								idx_q <= idx_nx;
								if (idx_nx >= clen) begin
									lit_q <= {5'd0, d_lits};
									dist_q <= d_dist;
									len_q <= d_len;
									if (d_lits != 2'd0) begin
										phase_q <= PH_LITPRE;
									end else begin
										bad_q <= c_bad;
										phase_q <= PH_CMD;
										st_q <= ST_CRD;
									end
								end
							end
							PH_LITPRE: begin
								lit_q <= lit_q - 7'd1;
								if (lit_q == 7'd1) begin
									bad_q <= c_bad;
									phase_q <= PH_CMD;
									st_q <= ST_CRD;
								end else begin
									st_q <= ST_FIN;
								end
							end
							PH_LITRUN: begin
								lit_q <= lit_q - 7'd1;
								if (lit_q == 7'd1) begin
									phase_q <= PH_CMD;
								end
								st_q <= ST_FIN;
							end
							PH_TRAIL: begin
								lit_q <= lit_q - 7'd1;
								if (lit_q == 7'd1) begin
									end_q <= 1'b1;
									phase_q <= PH_FLAGS;
								end
								st_q <= ST_FIN;
							end
							default: phase_q <= PH_FLAGS;
						endcase
					end
				end
				ST_CRD: st_q <= ST_CWR;
				ST_CWR: begin
					if (stat.push_ready) begin
						len_q <= len_q - LEN_W'(1);
						st_q <= (len_q == LEN_W'(1)) ? ST_FIN : ST_CRD;
					end
				end
				ST_FIN: begin
					if (stat.fin_ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	lzcd_hist_mem #(
		.AW(AW)
	) u_hist (
		.clk(clk),
		.we(ctl.push),
		.waddr(bw_q[AW-1:0]),
		.wdata(ctl.data),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	lzcd_packer u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.total_size(size_q),
		.stat(stat),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

endmodule

// ===== rtl/core/lzcd_hist_mem.sv =====
module lzcd_hist_mem #(
	parameter int AW = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/lzcd_packer.sv =====
module lzcd_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lzcd_pkg::pk_ctl_t             ctl,
	input  logic [lzcd_pkg::SIZE_W-1:0]   total_size,
	output lzcd_pkg::pk_stat_t            stat,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [lzcd_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast,
	output logic [1:0]                    m_axis_tuser
);
	import lzcd_pkg::*;

	logic [7:0]       fill_q [CHUNK_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic [CHUNK_BYTES*8-1:0] lanes;
	logic out_free, full, ship_mid, ship;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign full = (cnt_q == CNT_W'(CHUNK_BYTES));
	assign stat.push_ready = !full || out_free;
	assign stat.fin_ready = out_free;
	assign ship_mid = ctl.push && full;
	assign ship = ship_mid || ctl.fin;

	always_comb begin
		for (int i = 0; i < CHUNK_BYTES; i++) begin
			lanes[8*i +: 8] = (CNT_W'(i) < cnt_q) ? fill_q[i] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (ship) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			if (ctl.fin) begin
				cnt_q <= '0;
			end else if (ship_mid) begin
				cnt_q <= CNT_W'(1);
			end else if (ctl.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (full) begin
				fill_q[0] <= ctl.data;
			end else begin
				fill_q[cnt_q[CNT_W-2:0]] <= ctl.data;
			end
		end
		if (ship) begin
			m_axis_tdata <= {2'b00, total_size, cnt_q, lanes};
			m_axis_tlast <= ctl.fin;
			m_axis_tuser <= {ctl.bad, ctl.fin && ctl.stream_end};
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lzcd_pkg::*;

	localparam int HIST_N = 131072;
	localparam int RUN_LIMIT = 4000000;
	localparam int CALM_FROM = 3000;
	localparam int CALM_TO = 6000;
	localparam int SQUEEZE_CYCLES = 2500;

	typedef struct packed {
		logic [255:0] lanes;
		logic [5:0]   cnt;
		logic         last;
		logic         fin;
		logic [23:0]  size;
		logic         bad;
	} chunk_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_wdata = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = 8'h00;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic                 m_axis_tlast;
	logic [1:0]           m_axis_tuser;

	lz_command_stream_decompressor_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	logic [7:0] feed_q[$];
	chunk_t     chunk_q[$];
	int         errors = 0;
	int         bytes_in = 0;
	int         words_out = 0;
	int         ends_seen = 0;
	int         bad_seen = 0;
	int         cycle = 0;
	int         gen_written;

	// decoder mirror
	phase_t      ph;
	logic [7:0]  hist [0:HIST_N-1];
	logic [31:0] cmd_bytes;
	int unsigned cmd_idx;
	int unsigned lit_left;
	logic [23:0] written;
	logic [23:0] hdr_size;
	bit          skip_hdr;
	int unsigned copy_dist;
	int unsigned copy_len;
	bit          full_decode;
	logic [7:0]  step_bytes[$];

	function automatic int unsigned cmd_len(logic [7:0] b0);
		if (b0 < CMD_SHORT_LIM) return 2;
		if (b0 < CMD_MID_LIM) return 3;
		if (b0 < CMD_LONG_LIM) return 4;
		return 1;
	endfunction

	task automatic emit_byte(logic [7:0] v);
		hist[written % HIST_N] = v;
		written = written + 24'd1;
		step_bytes.push_back(v);
	endtask

	task automatic do_copy(output bit bad);
		logic [7:0] v;
		bad = (copy_dist > written) || (copy_dist > HIST_N);
		for (int unsigned i = 0; i < copy_len; i++) begin
			v = 8'h00;
			if (!bad)
				v = hist[(written - copy_dist) % HIST_N];
			emit_byte(v);
		end
	endtask

	task automatic split_copy();
		logic [7:0] b0, b1, b2, b3;
		b0 = cmd_bytes[7:0];
		b1 = cmd_bytes[15:8];
		b2 = cmd_bytes[23:16];
		b3 = cmd_bytes[31:24];
		if (b0 < CMD_SHORT_LIM) begin
			lit_left = b0[1:0];
			copy_len = b0[4:2] + 3;
			copy_dist = {b0[6:5], b1} + 1;
		end else if (b0 < CMD_MID_LIM) begin
			lit_left = b1[7:6];
			copy_len = b0[5:0] + 4;
			copy_dist = {b1[5:0], b2} + 1;
		end else begin
			lit_left = b0[1:0];
			copy_len = {b0[3:2], b3} + 5;
			copy_dist = {b0[4], b1, b2} + 1;
		end
	endtask

	task automatic decode_byte(logic [7:0] b);
		bit fin, bad;
		int n, cnt;
		chunk_t c;
		fin = 0;
		bad = 0;
		step_bytes.delete();
		case (ph)
			PH_FLAGS: begin
				skip_hdr = b[0];
				hdr_size = '0;
				written = '0;
				cmd_idx = 0;
				ph = PH_MAGIC;
			end
			PH_MAGIC: begin
				cmd_idx = 0;
				ph = skip_hdr ? PH_SKIP : PH_SIZE;
			end
			PH_SKIP: begin
				cmd_idx++;
				if (cmd_idx >= 3) begin
					cmd_idx = 0;
					ph = PH_SIZE;
				end
			end
			PH_SIZE: begin
				hdr_size = {hdr_size[15:0], b};
				cmd_idx++;
				if (cmd_idx >= 3) begin
					cmd_idx = 0;
					if (full_decode) begin
						ph = PH_CMD;
					end else begin
						fin = 1;
						ph = PH_FLAGS;
					end
				end
			end
			PH_CMD: begin
				cmd_bytes = {24'h0, b};
				cmd_idx = 1;
				if (cmd_len(b) > 1) begin
					ph = PH_CMDMORE;
				end else if (b < CMD_STOP_LIM) begin
					lit_left = (b[4:0] + 1) * 4;
					ph = PH_LITRUN;
				end else begin
					lit_left = b[1:0];
					if (lit_left == 0) begin
						fin = 1;
						ph = PH_FLAGS;
					end else begin
						ph = PH_TRAIL;
					end
				end
			end
			PH_CMDMORE: begin
				cmd_bytes[8*(cmd_idx%4) +: 8] = b;
				cmd_idx = (cmd_idx + 1) % 8;
				if (cmd_idx >= cmd_len(cmd_bytes[7:0])) begin
					split_copy();
					if (lit_left > 0) begin
						ph = PH_LITPRE;
					end else begin
						do_copy(bad);
						ph = PH_CMD;
					end
				end
			end
			PH_LITPRE: begin
				emit_byte(b);
				if (lit_left > 0) lit_left--;
				if (lit_left == 0) begin
					do_copy(bad);
					ph = PH_CMD;
				end
			end
			PH_LITRUN: begin
				emit_byte(b);
				if (lit_left > 0) lit_left--;
				if (lit_left == 0) ph = PH_CMD;
			end
			default: begin
				emit_byte(b);
				if (lit_left > 0) lit_left--;
				if (lit_left == 0) begin
					fin = 1;
					ph = PH_FLAGS;
				end
			end
		endcase
		if (step_bytes.size() == 0 && !fin) return;
		n = (step_bytes.size() + CHUNK_BYTES - 1) / CHUNK_BYTES;
		if (n == 0) n = 1;
		for (int k = 0; k < n; k++) begin
			c = '0;
			cnt = step_bytes.size() - k * CHUNK_BYTES;
			if (cnt > CHUNK_BYTES) cnt = CHUNK_BYTES;
			for (int i = 0; i < cnt; i++)
				c.lanes[8*i +: 8] = step_bytes[k*CHUNK_BYTES + i];
			c.cnt = 6'(cnt);
			c.last = (k == n - 1);
			c.fin = fin && (k == n - 1);
			c.size = hdr_size;
			c.bad = bad;
			chunk_q.push_back(c);
		end
	endtask

	task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
		$display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
		errors++;
	endtask

	// send side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata);
				bytes_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (feed_q.size() > 0 && ((cycle >= CALM_FROM && cycle < CALM_TO)
						|| $urandom_range(0, 99) >= 32)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= feed_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receive side
	int  squeeze_left = 0;
	bit  squeezed = 0;
	always @(posedge clk or negedge arst_n) begin
		chunk_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_out++;
				if (m_axis_tuser[0]) ends_seen++;
				if (m_axis_tuser[1]) bad_seen++;
				if (chunk_q.size() == 0) begin
					report_mismatch("unexpected word", m_axis_tdata[255:0], '0);
				end else begin
					want = chunk_q.pop_front();
					if (m_axis_tdata[255:0] !== want.lanes)
						report_mismatch("lanes", m_axis_tdata[255:0], want.lanes);
					if (m_axis_tdata[261:256] !== want.cnt)
						report_mismatch("byte_count", m_axis_tdata[261:256], want.cnt);
					if (m_axis_tdata[285:262] !== want.size)
						report_mismatch("total_size", m_axis_tdata[285:262], want.size);
					if (m_axis_tdata[287:286] !== 2'b00)
						report_mismatch("fill", m_axis_tdata[287:286], '0);
					if (m_axis_tlast !== want.last)
						report_mismatch("chunk_last", m_axis_tlast, want.last);
					if (m_axis_tuser[0] !== want.fin)
						report_mismatch("stream_end", m_axis_tuser[0], want.fin);
					if (m_axis_tuser[1] !== want.bad)
						report_mismatch("bad_distance", m_axis_tuser[1], want.bad);
				end
			end
			if (!squeezed && words_out >= 60) begin
				squeezed = 1;
				squeeze_left = SQUEEZE_CYCLES;
			end
			if (squeeze_left > 0) begin
				squeeze_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (cycle >= CALM_FROM && cycle < CALM_TO)
					|| $urandom_range(0, 99) >= 32;
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_header(bit skip, logic [23:0] sz);
		feed_q.push_back({7'($urandom_range(0, 127)), skip});
		feed_q.push_back(8'($urandom_range(0, 255)));
		if (skip)
			repeat (3) feed_q.push_back(8'($urandom_range(0, 255)));
		feed_q.push_back(sz[23:16]);
		feed_q.push_back(sz[15:8]);
		feed_q.push_back(sz[7:0]);
		gen_written = 0;
	endtask

	task automatic add_literal_run(int unsigned n);
		feed_q.push_back(8'hE0 | 8'(n));
		repeat (4 * (n + 1)) feed_q.push_back(8'($urandom_range(0, 255)));
		gen_written += 4 * (n + 1);
	endtask

	task automatic add_copy(int form, int unsigned lit, int unsigned ln, int unsigned d);
		int unsigned dm, lm;
		dm = d - 1;
		case (form)
			0: begin
				feed_q.push_back({1'b0, dm[9:8], 3'(ln - 3), 2'(lit)});
				feed_q.push_back(dm[7:0]);
			end
			1: begin
				feed_q.push_back({2'b10, 6'(ln - 4)});
				feed_q.push_back({2'(lit), dm[13:8]});
				feed_q.push_back(dm[7:0]);
			end
			default: begin
				lm = ln - 5;
				feed_q.push_back({3'b110, dm[16], lm[9:8], 2'(lit)});
				feed_q.push_back(dm[15:8]);
				feed_q.push_back(dm[7:0]);
				feed_q.push_back(lm[7:0]);
			end
		endcase
		repeat (lit) feed_q.push_back(8'($urandom_range(0, 255)));
		gen_written += lit + ln;
	endtask

	task automatic add_stream();
		int form, have, maxd, ln, d, lit, t;
		add_header(1'($urandom_range(0, 1)), 24'($urandom));
		repeat ($urandom_range(2, 8)) begin
			lit = $urandom_range(0, 3);
			if ($urandom_range(0, 9) < 3 || gen_written + lit == 0) begin
				add_literal_run($urandom_range(0, 9) == 0 ? $urandom_range(0, 27)
					: $urandom_range(0, 3));
			end else begin
				form = $urandom_range(0, 2);
				have = gen_written + lit;
				maxd = form == 0 ? 1024 : form == 1 ? 16384 : HIST_N;
				case (form)
					0: ln = $urandom_range(3, 10);
					1: ln = $urandom_range(4, 67);
					default: ln = $urandom_range(0, 40) == 0 ? $urandom_range(900, 1028)
						: $urandom_range(5, 40);
				endcase
				if ($urandom_range(0, 11) == 0 && have < maxd)
					d = $urandom_range(have + 1, have + 64 < maxd ? have + 64 : maxd);
				else
					d = $urandom_range(1, have < maxd ? have : maxd);
				add_copy(form, lit, ln, d);
			end
		end
		t = $urandom_range(0, 3);
		feed_q.push_back(CMD_STOP_LIM | 8'(t));
		repeat (t) feed_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic settle();
		while (feed_q.size() > 0 || s_axis_tvalid || chunk_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_decode(bit v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		full_decode = v;
		@(posedge clk);
	endtask

	initial begin
		ph = PH_FLAGS;
		cmd_bytes = '0;
		cmd_idx = 0;
		lit_left = 0;
		written = '0;
		hdr_size = '0;
		skip_hdr = 0;
		copy_dist = 0;
		copy_len = 0;
		full_decode = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_decode(1);

		// skipped header bytes, widest size, overlapping copy, out-of-range copy,
		// terminator with three trailing bytes, then a short stream with an empty terminator
		feed_q = '{8'h01, 8'hFB, 8'h00, 8'hFF, 8'h5A, 8'hFF, 8'hFF, 8'hFF,
			8'hE0, 8'hFF, 8'h00, 8'hAA, 8'h55,
			8'h1C, 8'h03,
			8'hBF, 8'h3F, 8'hFF,
			8'hFF, 8'h80, 8'h01, 8'h7E,
			8'h00, 8'h10, 8'h00, 8'h00, 8'h01, 8'hFC};
		settle();

		set_decode(0);
		add_header(0, 24'h000000);
		add_header(1, 24'hFFFFFF);
		repeat (4) add_header(1'($urandom_range(0, 1)), 24'($urandom));
		settle();

		set_decode(1);
		while (bytes_in + feed_q.size() < 320) begin
			add_stream();
			while (feed_q.size() > 64) @(posedge clk);
		end
		repeat (30) feed_q.push_back(8'($urandom_range(0, 255)));
		while (feed_q.size() > 0 || s_axis_tvalid || chunk_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("run: %0d compressed bytes in, %0d output words checked", bytes_in, words_out);
		$display("     %0d stream ends, %0d words with bad distance", ends_seen, bad_seen);
		if (errors == 0 && chunk_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
